FILE: design/cput8_pkg.sv
// Shared types, constants and helpers of the code page to UTF-8 transcoder.
package cput8_pkg;

   // Translation table geometry.
   localparam int TBL_DEPTH = 128;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int SCAN_W    = TBL_AW + 1;
   localparam int LEN_W     = 3;
   localparam int ENTRY_W   = 40;
   localparam int BYTE_W    = 8;

   // Longest entry that is ever emitted.
   localparam logic [LEN_W-1:0] MAX_LEN = 3'd5;

   // First code point that the table covers.
   localparam int CODE_BASE = 128;

   // Lead bytes of the multi-byte sequences that are decoded.
   localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE2;
   localparam logic [BYTE_W-1:0] LEAD_C2    = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD_C3    = 8'hC3;
   localparam logic [BYTE_W-1:0] LEAD_C4    = 8'hC4;
   localparam logic [BYTE_W-1:0] LEAD_C5    = 8'hC5;
   localparam logic [BYTE_W-1:0] LEAD_C6    = 8'hC6;
   localparam logic [BYTE_W-1:0] LEAD_CB    = 8'hCB;
   localparam logic [BYTE_W-1:0] LEAD_D0    = 8'hD0;
   localparam logic [BYTE_W-1:0] LEAD_D1    = 8'hD1;
   localparam logic [BYTE_W-1:0] LEAD_D2    = 8'hD2;

   // Request function codes.
   typedef enum logic [1:0] {
      FN_LOAD   = 2'd0,
      FN_ENCODE = 2'd1,
      FN_DECODE = 2'd2,
      FN_NONE   = 2'd3
   } func_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FETCH  = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // Table write port.
   typedef struct packed {
      logic               en;
      logic [TBL_AW-1:0]  idx;
      logic [LEN_W-1:0]   len;
      logic [ENTRY_W-1:0] bytes;
   } tbl_wr_type;

   // Sequence that the decode search looks for.
   typedef struct packed {
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] second;
      logic [BYTE_W-1:0] third;
      logic              three;
   } key_type;

   // Number of continuation bytes that follow a lead byte.
   function automatic logic [1:0] cont_count(input logic [BYTE_W-1:0] b);
      logic [1:0] n;
      case (b)
         LEAD_THREE: n = 2'd2;
         LEAD_C2, LEAD_C3, LEAD_C4, LEAD_C5, LEAD_C6,
         LEAD_CB, LEAD_D0, LEAD_D1, LEAD_D2: n = 2'd1;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: design/cput8_table.sv
// Translation table memory with the byte compare used by the decode search.
module cput8_table (
   input  logic                              clock,
   input  cput8_pkg::tbl_wr_type             wr,
   input  logic                              rd_en,
   input  logic [cput8_pkg::TBL_AW-1:0]      rd_addr,
   input  cput8_pkg::key_type                key,
   output logic [cput8_pkg::LEN_W-1:0]       rd_len,
   output logic [cput8_pkg::ENTRY_W-1:0]     rd_bytes,
   output logic                              hit
);
   import cput8_pkg::*;

   logic [LEN_W-1:0]   len_mem_ff   [TBL_DEPTH];
   logic [ENTRY_W-1:0] bytes_mem_ff [TBL_DEPTH];
   logic [LEN_W-1:0]   rd_len_ff;
   logic [ENTRY_W-1:0] rd_bytes_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         len_mem_ff[wr.idx]   <= wr.len;
         bytes_mem_ff[wr.idx] <= wr.bytes;
      end
      if (rd_en) begin
         rd_len_ff   <= len_mem_ff[rd_addr];
         rd_bytes_ff <= bytes_mem_ff[rd_addr];
      end
   end

   assign rd_len   = rd_len_ff;
   assign rd_bytes = rd_bytes_ff;

   // Compare the entry just read against the gathered sequence.
   assign hit = (rd_bytes_ff[7:0] == key.lead) &&
                (rd_bytes_ff[15:8] == key.second) &&
                (!key.three || (rd_bytes_ff[23:16] == key.third));

endmodule

FILE: design/codepage_utf8_transcoder_core.sv
// Top level of the single-byte code page to UTF-8 transcoder.
//
// Requests arrive on the req_ stream: tuser selects the function (load a table
// entry, encode a byte, decode a byte), tlast marks the last byte of a string.
// Results leave on the rsp_ stream one byte at a time; tlast marks the final
// byte caused by a request and tuser flags a missing glyph after a failed
// decode search.
// The block takes one request at a time. A load, or a byte that emits nothing
// and needs no table read, leaves the sequencer idle; a pass-through byte goes
// through the emit state. An encode of an upper code point reads its table
// entry in the fetch state, then emits its bytes (up to 5) one per cycle unless
// the receiver stalls; an empty entry emits nothing.
// A completed decode sequence walks the table one entry per cycle through the
// single read port until the match or the miss is known, then emits one byte.
// A result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the sequencer holds and req_tready stays low
// until the last result byte of the current request has entered the register.
// Reset clears the string state and the stream control; the table keeps its
// contents undefined until software loads each entry.
module codepage_utf8_transcoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [14:8] entry_index, [17:15] entry_length,
   // [25:18] entry_byte_one, [33:26] entry_byte_two, [41:34] entry_byte_three,
   // [49:42] entry_byte_four, [57:50] entry_byte_five, [63:58] zero
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // [0] glyph_missing
   output logic        rsp_tuser
);
   import cput8_pkg::*;

   state_type          state_ff, state_in;
   logic [BYTE_W-1:0]  lead_ff, lead_in;
   logic [BYTE_W-1:0]  second_ff, second_in;
   logic [1:0]         need_ff, need_in;
   logic               stop_ff, stop_in;
   key_type            key_ff, key_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               probe_vld_ff, probe_vld_in;
   logic [TBL_AW-1:0]  probe_idx_ff, probe_idx_in;
   logic [ENTRY_W-1:0] emit_buf_ff, emit_buf_in;
   logic [LEN_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic               emit_miss_ff, emit_miss_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_miss_ff, rsp_miss_in;

   logic               req_accept;
   logic               out_free;
   func_type           func;
   logic [BYTE_W-1:0]  in_byte;
   logic [LEN_W-1:0]   fetch_len;
   tbl_wr_type         tbl_wr;
   logic               rd_en;
   logic [TBL_AW-1:0]  rd_addr;
   logic [LEN_W-1:0]   tbl_len;
   logic [ENTRY_W-1:0] tbl_bytes;
   logic               tbl_hit;

   // Request field views.
   assign func       = func_type'(req_tuser);
   assign in_byte    = req_tdata[7:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign fetch_len  = (tbl_len > MAX_LEN) ? MAX_LEN : tbl_len;

   cput8_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .key      (key_ff),
      .rd_len   (tbl_len),
      .rd_bytes (tbl_bytes),
      .hit      (tbl_hit)
   );

   // Sequencer and string state.
   always_comb begin
      state_in     = state_ff;
      lead_in      = lead_ff;
      second_in    = second_ff;
      need_in      = need_ff;
      stop_in      = stop_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      probe_vld_in = 1'b0;
      probe_idx_in = scan_ff[TBL_AW-1:0];
      emit_buf_in  = emit_buf_ff;
      emit_cnt_in  = emit_cnt_ff;
      emit_miss_in = emit_miss_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_miss_in  = rsp_miss_ff;
      tbl_wr.en    = 1'b0;
      tbl_wr.idx   = req_tdata[14:8];
      tbl_wr.len   = req_tdata[17:15];
      tbl_wr.bytes = req_tdata[57:18];
      rd_en        = 1'b0;
      rd_addr      = scan_ff[TBL_AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (func)
                  FN_LOAD: begin
                     tbl_wr.en = 1'b1;
                  end
                  FN_ENCODE: begin
                     if (!stop_ff) begin
                        lead_in   = '0;
                        second_in = '0;
                        need_in   = '0;
                        if (in_byte == '0) begin
                           stop_in = 1'b1;
                        end else if (!in_byte[7]) begin
                           emit_buf_in  = {32'd0, in_byte};
                           emit_cnt_in  = 3'd1;
                           emit_miss_in = 1'b0;
                           state_in     = ST_EMIT;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = in_byte[TBL_AW-1:0];
                           state_in = ST_FETCH;
                        end
                     end
                  end
                  FN_DECODE: begin
                     if (!stop_ff) begin
                        if (need_ff == 2'd0) begin
                           if (in_byte == '0) begin
                              stop_in = 1'b1;
                           end else if (cont_count(in_byte) == 2'd0) begin
                              emit_buf_in  = {32'd0, in_byte};
                              emit_cnt_in  = 3'd1;
                              emit_miss_in = 1'b0;
                              state_in     = ST_EMIT;
                           end else begin
                              lead_in   = in_byte;
                              second_in = '0;
                              need_in   = cont_count(in_byte);
                           end
                        end else if (need_ff == 2'd1) begin
                           // Sequence complete: start the table walk.
                           need_in    = '0;
                           key_in.lead = lead_ff;
                           if (cont_count(lead_ff) == 2'd2) begin
                              key_in.second = second_ff;
                              key_in.third  = in_byte;
                              key_in.three  = 1'b1;
                           end else begin
                              second_in     = in_byte;
                              key_in.second = in_byte;
                              key_in.third  = '0;
                              key_in.three  = 1'b0;
                           end
                           scan_in  = '0;
                           state_in = ST_SEARCH;
                        end else begin
                           second_in = in_byte;
                           need_in   = 2'd1;
                        end
                     end
                  end
                  default: ;
               endcase
               // End of string drops any pending sequence and the NUL stop.
               if (req_tlast && (func == FN_ENCODE || func == FN_DECODE)) begin
                  lead_in   = '0;
                  second_in = '0;
                  need_in   = '0;
                  stop_in   = 1'b0;
               end
            end
         end
         ST_FETCH: begin
            if (fetch_len == '0) begin
               state_in = ST_IDLE;
            end else begin
               emit_buf_in  = tbl_bytes;
               emit_cnt_in  = fetch_len;
               emit_miss_in = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_SEARCH: begin
            // One entry read per cycle; its compare uses the registered read data.
            if (probe_vld_ff && tbl_hit) begin
               emit_buf_in  = {32'd0, 8'(9'(CODE_BASE) + 9'(probe_idx_ff))};
               emit_cnt_in  = 3'd1;
               emit_miss_in = 1'b0;
               state_in     = ST_EMIT;
            end else if (probe_vld_ff && probe_idx_ff == TBL_AW'(TBL_DEPTH - 1)) begin
               emit_buf_in  = {32'd0, key_ff.lead};
               emit_cnt_in  = 3'd1;
               emit_miss_in = 1'b1;
               state_in     = ST_EMIT;
            end else if (!scan_ff[TBL_AW]) begin
               rd_en        = 1'b1;
               probe_vld_in = 1'b1;
               scan_in      = scan_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // Shift the buffered bytes into the output register.
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_byte_in = emit_buf_ff[7:0];
               rsp_last_in = (emit_cnt_ff == 3'd1);
               rsp_miss_in = emit_miss_ff;
               emit_buf_in = emit_buf_ff >> BYTE_W;
               emit_cnt_in = emit_cnt_ff - 1'b1;
               if (emit_cnt_ff == 3'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lead_ff      <= '0;
         second_ff    <= '0;
         need_ff      <= '0;
         stop_ff      <= 1'b0;
         probe_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
         need_ff      <= need_in;
         stop_ff      <= stop_in;
         probe_vld_ff <= probe_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      probe_idx_ff <= probe_idx_in;
      emit_buf_ff  <= emit_buf_in;
      emit_cnt_ff  <= emit_cnt_in;
      emit_miss_ff <= emit_miss_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_miss_ff  <= rsp_miss_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_miss_ff;

`ifndef SYNTHESIS
   // A missing glyph is always the only byte of its run.
   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_miss_ff |-> rsp_last_ff)
      else $error("glyph_missing flagged on a byte that is not last");

   // The emit buffer never holds an empty or over-long run.
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> emit_cnt_ff != '0 && emit_cnt_ff <= MAX_LEN)
      else $error("emit count out of range");

   // Table probes only come from the search walk.
   a_probe_src: assert property (@(posedge clock) disable iff (reset)
      probe_vld_ff |-> $past(state_ff == ST_SEARCH))
      else $error("table probe outside the search");

   // At most two continuation bytes are ever outstanding.
   a_need_range: assert property (@(posedge clock) disable iff (reset)
      need_ff != 2'd3)
      else $error("pending count out of range");

   // A new result is loaded only when the previous one has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_tready |=> rsp_vld_ff && $stable(rsp_byte_ff))
      else $error("result register overwritten while stalled");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the code page to UTF-8 transcoder core.
module tb;
   import cput8_pkg::*;

   // One byte on the response stream.
   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       missing;
   } out_item_type;

   // Tracks the translation table and the string state and holds the bytes still owed.
   class transcode_scoreboard;
      logic [LEN_W-1:0]   cp_len [TBL_DEPTH];
      logic [ENTRY_W-1:0] cp_seq [TBL_DEPTH];
      logic [7:0]         lead_byte;
      logic [7:0]         second_byte;
      logic [1:0]         still_needed;
      logic               nul_stop;
      out_item_type       due_bytes [$];
      int                 fails;

      function new();
         foreach (cp_len[i]) begin
            cp_len[i] = '0;
            cp_seq[i] = '0;
         end
         fails = 0;
         clear_string();
      endfunction

      function void clear_string();
         lead_byte    = '0;
         second_byte  = '0;
         still_needed = '0;
         nul_stop     = 1'b0;
      endfunction

      function void add_result(logic [7:0] value, logic last, logic missing);
         out_item_type r;
         r.value   = value;
         r.last    = last;
         r.missing = missing;
         due_bytes.push_back(r);
      endfunction

      // Continuation bytes that follow a lead byte.
      function int continuation_count(logic [7:0] b);
         case (b)
            LEAD_THREE: return 2;
            LEAD_C2, LEAD_C3, LEAD_C4, LEAD_C5, LEAD_C6,
            LEAD_CB, LEAD_D0, LEAD_D1, LEAD_D2: return 1;
            default: return 0;
         endcase
      endfunction

      // ASCII bytes pass through; upper code points expand into the bytes of their table entry.
      function void encode_char(logic [7:0] b);
         int n;
         if (b < CODE_BASE) begin
            add_result(b, 1'b1, 1'b0);
            return;
         end
         n = cp_len[b[6:0]];
         if (n > MAX_LEN) n = MAX_LEN;
         for (int i = 0; i < n; i++)
            add_result(cp_seq[b[6:0]][8*i +: 8], i == n - 1, 1'b0);
      endfunction

      // First entry in ascending order whose leading bytes match wins.
      function void search_table(logic [7:0] third, bit three);
         for (int i = 0; i < TBL_DEPTH; i++) begin
            if (cp_seq[i][7:0] == lead_byte && cp_seq[i][15:8] == second_byte &&
                (!three || cp_seq[i][23:16] == third)) begin
               add_result(8'(CODE_BASE + i), 1'b1, 1'b0);
               return;
            end
         end
         add_result(lead_byte, 1'b1, 1'b1);
      endfunction

      function void decode_char(logic [7:0] b);
         int n;
         if (still_needed == 0) begin
            if (b == 8'h00) begin
               nul_stop = 1'b1;
               return;
            end
            n = continuation_count(b);
            if (n == 0) begin
               add_result(b, 1'b1, 1'b0);
               return;
            end
            lead_byte    = b;
            second_byte  = '0;
            still_needed = 2'(n);
         end else if (still_needed == 2) begin
            second_byte  = b;
            still_needed = 2'd1;
         end else begin
            still_needed = '0;
            if (continuation_count(lead_byte) == 2) begin
               search_table(b, 1'b1);
            end else begin
               second_byte = b;
               search_table(8'h00, 1'b0);
            end
         end
      endfunction

      // Called at the edge where a request is accepted.
      function void note_request(func_type fn, logic [7:0] b, logic last,
                                 logic [6:0] idx, logic [2:0] len, logic [39:0] bytes);
         if (fn == FN_LOAD) begin
            cp_len[idx] = len;
            cp_seq[idx] = bytes;
            return;
         end
         if (fn == FN_NONE) return;
         if (!nul_stop) begin
            if (fn == FN_ENCODE) begin
               lead_byte    = '0;
               second_byte  = '0;
               still_needed = '0;
               if (b == 8'h00) nul_stop = 1'b1;
               else encode_char(b);
            end else begin
               decode_char(b);
            end
         end
         if (last) clear_string();
      endfunction

      function void check_result(logic [7:0] value, logic last, logic missing);
         out_item_type e;
         if (due_bytes.size() == 0) begin
            $error("out_byte %h arrived with no request owing it", value);
            fails++;
            return;
         end
         e = due_bytes.pop_front();
         if (value !== e.value) begin
            $error("out_byte expected %h actual %h", e.value, value);
            fails++;
         end
         if (last !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, last);
            fails++;
         end
         if (missing !== e.missing) begin
            $error("glyph_missing expected %b actual %b", e.missing, missing);
            fails++;
         end
      endfunction

      function void close_out();
         if (due_bytes.size() != 0) begin
            $error("%0d result bytes never arrived", due_bytes.size());
            fails++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic [1:0]  req_tuser  = FN_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   transcode_scoreboard model;
   bit                  quiet = 1'b0;
   int                  stall_left = 0;
   logic [7:0]          lead_list [10] = '{LEAD_C2, LEAD_C3, LEAD_C4, LEAD_C5, LEAD_C6,
                                           LEAD_CB, LEAD_D0, LEAD_D1, LEAD_D2, LEAD_THREE};

   codepage_utf8_transcoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stalls now and then.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(99) < 3) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted result is checked against the oldest owed byte.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // Presents one request and returns at the edge where it is accepted.
   task automatic send_request(func_type fn, logic [7:0] data, logic last,
                               logic [6:0] idx, logic [2:0] len, logic [39:0] bytes);
      if (!quiet && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tlast  <= last;
      req_tdata  <= {6'b0, bytes, len, idx, data};
      do @(posedge clock); while (!req_tready);
      model.note_request(fn, data, last, idx, len, bytes);
   endtask

   // String byte request; the table fields carry noise that must be ignored.
   task automatic send_text(func_type fn, logic [7:0] data, logic last);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      send_request(fn, data, last, noise[46:40], noise[49:47], noise[39:0]);
   endtask

   task automatic load_entry(logic [6:0] idx, logic [2:0] len, logic [39:0] bytes);
      send_request(FN_LOAD, 8'($urandom), 1'($urandom), idx, len, bytes);
   endtask

   // Table content biased toward decodable sequences, with repeats so order matters.
   function automatic logic [39:0] make_entry();
      logic [39:0] e;
      int          pick;
      e    = {8'($urandom), $urandom};
      pick = $urandom_range(99);
      if (pick < 40) begin
         e[7:0]  = lead_list[$urandom_range(8)];
         e[15:8] = 8'($urandom_range(8'h87, 8'h80));
      end else if (pick < 70) begin
         e[7:0]   = LEAD_THREE;
         e[15:8]  = 8'($urandom_range(8'h83, 8'h80));
         e[23:16] = 8'($urandom_range(8'h87, 8'h80));
      end
      return e;
   endfunction

   initial begin
      int          sent;
      int          pick;
      int          nc;
      logic        last;
      logic        cut;
      logic [39:0] e;
      logic [7:0]  b;

      model = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Every entry is loaded before any string byte can read the table.
      for (int i = 0; i < TBL_DEPTH; i++)
         load_entry(7'(i), 3'($urandom_range(7)), make_entry());

      // Known entries: full length, zero length, and a length above five.
      load_entry(7'd0,   3'd5, 40'hF1_E1_D1_A9_C3);
      load_entry(7'd1,   3'd0, 40'hFF_FF_FF_FF_FF);
      load_entry(7'd127, 3'd7, 40'h00_7F_94_80_E2);

      // Encode: ASCII extremes, lowest and highest upper code points, empty entry.
      send_text(FN_ENCODE, 8'h01, 1'b0);
      send_text(FN_ENCODE, 8'h7F, 1'b0);
      send_text(FN_ENCODE, 8'h80, 1'b0);
      send_text(FN_ENCODE, 8'hFF, 1'b0);
      send_text(FN_ENCODE, 8'h81, 1'b1);

      // Decode: pass-through, two-byte and three-byte hits, miss on a NUL continuation.
      send_text(FN_DECODE, 8'h41, 1'b0);
      send_text(FN_DECODE, LEAD_C3, 1'b0);
      send_text(FN_DECODE, 8'hA9, 1'b0);
      send_text(FN_DECODE, LEAD_THREE, 1'b0);
      send_text(FN_DECODE, 8'h80, 1'b0);
      send_text(FN_DECODE, 8'h94, 1'b0);
      send_text(FN_DECODE, LEAD_D2, 1'b0);
      send_text(FN_DECODE, 8'h00, 1'b1);

      // NUL at the start of a character silences the rest of the string.
      send_text(FN_DECODE, 8'h00, 1'b0);
      send_text(FN_ENCODE, 8'h80, 1'b0);
      send_request(FN_NONE, 8'h41, 1'b1, 7'h7F, 3'd7, '1);
      send_text(FN_DECODE, 8'h41, 1'b1);
      send_text(FN_ENCODE, 8'h00, 1'b0);
      send_text(FN_ENCODE, 8'hFF, 1'b1);

      // Sequence cut short by the end of the string.
      send_text(FN_DECODE, LEAD_THREE, 1'b0);
      send_text(FN_DECODE, 8'h80, 1'b1);

      // Encode drops a pending sequence; a load in the middle leaves it alone.
      send_text(FN_DECODE, LEAD_C3, 1'b0);
      send_text(FN_ENCODE, 8'h41, 1'b0);
      send_text(FN_DECODE, 8'hA9, 1'b0);
      send_text(FN_DECODE, LEAD_C3, 1'b0);
      load_entry(7'd5, 3'd2, 40'h00_00_00_A9_C3);
      send_text(FN_DECODE, 8'hA9, 1'b1);

      // Random part: mostly well-formed sequences, with noise and broken strings.
      sent = 0;
      while (sent < 110) begin
         quiet = (sent >= 40 && sent < 75);
         pick  = $urandom_range(99);
         last  = ($urandom_range(99) < 15);
         if (pick < 45) begin
            e  = model.cp_seq[$urandom_range(TBL_DEPTH - 1)];
            nc = model.continuation_count(e[7:0]);
            if (nc == 0) begin
               e[7:0] = lead_list[$urandom_range(9)];
               nc     = model.continuation_count(e[7:0]);
            end
            cut = ($urandom_range(99) < 8);
            send_text(FN_DECODE, e[7:0], cut);
            if (nc == 2) send_text(FN_DECODE, e[15:8], 1'b0);
            send_text(FN_DECODE, (nc == 2) ? e[23:16] : e[15:8], last);
            sent += nc + 1;
         end else if (pick < 65) begin
            b = ($urandom_range(99) < 4) ? 8'h00 : 8'($urandom);
            send_text(FN_ENCODE, b, last);
            sent++;
         end else if (pick < 85) begin
            b = ($urandom_range(99) < 6) ? 8'h00 : 8'($urandom);
            send_text(FN_DECODE, b, last);
            sent++;
         end else if (pick < 95) begin
            load_entry(7'($urandom), 3'($urandom), make_entry());
            sent++;
         end else begin
            send_text(FN_NONE, 8'($urandom), last);
            sent++;
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      // Drain, then allow a full table walk for anything unexpected.
      while (model.due_bytes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      model.close_out();
      if (model.fails == 0)
         $display("** codepage_utf8_transcoder_core: PASSED **");
      else
         $display("** codepage_utf8_transcoder_core: FAILED **");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("** codepage_utf8_transcoder_core: FAILED **");
      $finish;
   end

endmodule
